// ===== design/sprite_font_glyph_parser_macros.svh =====
`ifndef SPRITE_FONT_GLYPH_PARSER_MACROS_SVH
`define SPRITE_FONT_GLYPH_PARSER_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, quiet during reset
`define SFGP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising edge, quiet during reset
`define SFGP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/sfgp_pkg.sv =====
package sfgp_pkg;

	// Image and table limits
	localparam int MAX_IMAGE_WIDTH  = 256;
	localparam int MAX_IMAGE_HEIGHT = 256;
	localparam int MAX_GLYPHS       = 128;

	localparam int MAP_DEPTH = MAX_IMAGE_WIDTH * MAX_IMAGE_HEIGHT;
	localparam int MAP_AW    = $clog2(MAP_DEPTH);
	localparam int GLYPH_AW  = $clog2(MAX_GLYPHS);

	// Field widths
	localparam int DIM_W   = 9;
	localparam int POS_W   = 8;
	localparam int CHAN_W  = 8;
	localparam int COUNT_W = 8;
	localparam int CODE_W  = 8;

	localparam logic [COUNT_W-1:0] GLYPH_CAP  = COUNT_W'(MAX_GLYPHS);
	localparam logic [CODE_W-1:0]  FIRST_CODE = CODE_W'(32);
	localparam logic [CHAN_W-1:0]  CHAN_FULL  = CHAN_W'(255);
	localparam logic [DIM_W-1:0]   MAX_W_DIM  = DIM_W'(MAX_IMAGE_WIDTH);
	localparam logic [DIM_W-1:0]   MAX_H_DIM  = DIM_W'(MAX_IMAGE_HEIGHT);
	localparam logic [DIM_W-1:0]   RST_WIDTH  = DIM_W'(128);
	localparam logic [DIM_W-1:0]   RST_HEIGHT = DIM_W'(64);

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_EMPTY    = 2'd1,
		STAT_OVERFLOW = 2'd2,
		STAT_RANGE    = 2'd3
	} status_t;

	typedef enum logic {
		REQ_PUSH = 1'b0,
		REQ_READ = 1'b1
	} req_t;

	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		TS_IDLE,
		TS_PARSE,
		TS_READ
	} top_state_t;

	typedef enum logic [2:0] {
		SC_IDLE,
		SC_FIND,
		SC_HGT,
		SC_LINE,
		SC_GSTART,
		SC_WIDTH,
		SC_RECORD,
		SC_DONE
	} scan_state_t;

	// Clamped image size
	typedef struct packed {
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
	} dims_t;

	// One glyph record as stored in the table
	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
	} glyph_rec_t;

	typedef struct packed {
		logic                we;
		logic [GLYPH_AW-1:0] addr;
		glyph_rec_t          rec;
	} glyph_wr_t;

	// Pixel push from the request port
	typedef struct packed {
		logic valid;
		logic mag;
		logic last;
	} push_t;

	typedef struct packed {
		logic               done;
		logic [COUNT_W-1:0] count;
		status_t            status;
	} parse_stat_t;

endpackage

// ===== design/sfgp_parser.sv =====
// Separator map store and the scan engine that walks it after the last pixel
module sfgp_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sfgp_pkg::dims_t       dims,
	input  sfgp_pkg::push_t       push,
	output sfgp_pkg::glyph_wr_t   gwr,
	output sfgp_pkg::parse_stat_t stat
);

	// Separator map: one bit per pixel, registered read
	logic                               sep_map [sfgp_pkg::MAP_DEPTH];
	logic [sfgp_pkg::MAP_AW-1:0]        pix_addr_q;
	logic [sfgp_pkg::MAP_AW-1:0]        rd_addr;
	logic [sfgp_pkg::POS_W+sfgp_pkg::DIM_W-1:0] row_base;
	logic                               sep_s1;

	sfgp_pkg::scan_state_t state_q, state_d;
	logic                  pend_q, pend_d;

	// Scan position and measurements
	logic [sfgp_pkg::DIM_W-1:0]   prow_q;
	logic [sfgp_pkg::DIM_W:0]     pcol_q;
	logic [sfgp_pkg::DIM_W:0]     xp_q;
	logic [sfgp_pkg::DIM_W:0]     line_row_q;
	logic [sfgp_pkg::DIM_W:0]     step;
	logic [sfgp_pkg::POS_W-1:0]   ls_q, cs_q;
	logic [sfgp_pkg::DIM_W-1:0]   gh_q, gw_q;
	logic [sfgp_pkg::COUNT_W-1:0] count_q;
	sfgp_pkg::status_t            status_q;

	// Bound checks and scan decisions
	logic row_in, col_in, col_next_in, row_next_in, line_in, full;
	logic find_empty, hgt_end, probe_end;

	assign row_in      = prow_q < dims.h;
	assign col_in      = pcol_q < {1'b0, dims.w};
	assign col_next_in = (pcol_q + 1'b1) < {1'b0, dims.w};
	assign row_next_in = ({1'b0, prow_q} + 1'b1) < {1'b0, dims.h};
	assign line_in     = line_row_q < {1'b0, dims.h};
	assign full        = count_q >= sfgp_pkg::GLYPH_CAP;
	assign step        = {1'b0, gh_q} + {2'b00, ls_q};

	assign find_empty = pend_q && sep_s1 && !col_next_in && !row_next_in;
	assign hgt_end    = (!pend_q && !row_in) || (pend_q && sep_s1);
	assign probe_end  = (!pend_q && !col_in) || (pend_q && sep_s1);

	// Map address: row times width plus column
	assign row_base = prow_q[sfgp_pkg::POS_W-1:0] * dims.w;
	assign rd_addr  = row_base[sfgp_pkg::MAP_AW-1:0]
		+ sfgp_pkg::MAP_AW'(pcol_q[sfgp_pkg::POS_W-1:0]);

	always_ff @(posedge clk) begin
		if (push.valid) begin
			sep_map[pix_addr_q] <= push.mag;
		end
		sep_s1 <= sep_map[rd_addr];
	end

	// Next state and probe sequencing
	always_comb begin
		state_d = state_q;
		pend_d  = 1'b0;
		unique case (state_q)
			sfgp_pkg::SC_IDLE: begin
				if (push.valid && push.last) begin
					state_d = sfgp_pkg::SC_FIND;
				end
			end
			sfgp_pkg::SC_FIND: begin
				pend_d = !pend_q;
				if (find_empty) begin
					state_d = sfgp_pkg::SC_DONE;
				end else if (pend_q && !sep_s1) begin
					state_d = sfgp_pkg::SC_HGT;
				end
			end
			sfgp_pkg::SC_HGT: begin
				pend_d = !pend_q && !hgt_end;
				if (hgt_end) begin
					state_d = sfgp_pkg::SC_LINE;
				end
			end
			sfgp_pkg::SC_LINE: begin
				state_d = line_in ? sfgp_pkg::SC_GSTART : sfgp_pkg::SC_DONE;
			end
			sfgp_pkg::SC_GSTART: begin
				pend_d = !pend_q && !probe_end;
				if (probe_end) begin
					state_d = sfgp_pkg::SC_LINE;
				end else if (pend_q) begin
					state_d = sfgp_pkg::SC_WIDTH;
				end
			end
			sfgp_pkg::SC_WIDTH: begin
				pend_d = !pend_q && !probe_end;
				if (probe_end) begin
					state_d = sfgp_pkg::SC_RECORD;
				end
			end
			sfgp_pkg::SC_RECORD: begin
				state_d = full ? sfgp_pkg::SC_DONE : sfgp_pkg::SC_GSTART;
			end
			sfgp_pkg::SC_DONE: begin
				state_d = sfgp_pkg::SC_IDLE;
			end
			default: begin
				state_d = sfgp_pkg::SC_IDLE;
			end
		endcase
	end

	// Control state: sequencer, pixel pointer, count and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sfgp_pkg::SC_IDLE;
			pend_q     <= 1'b0;
			pix_addr_q <= '0;
			count_q    <= '0;
			status_q   <= sfgp_pkg::STAT_OK;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
			if (push.valid) begin
				pix_addr_q <= push.last ? '0 : pix_addr_q + 1'b1;
			end
			case (state_q)
				sfgp_pkg::SC_IDLE: begin
					if (push.valid && push.last) begin
						count_q  <= '0;
						status_q <= sfgp_pkg::STAT_OK;
					end
				end
				sfgp_pkg::SC_FIND: begin
					if (find_empty) begin
						status_q <= sfgp_pkg::STAT_EMPTY;
					end
				end
				sfgp_pkg::SC_RECORD: begin
					if (full) begin
						status_q <= sfgp_pkg::STAT_OVERFLOW;
					end else begin
						count_q <= count_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Scan datapath
	always_ff @(posedge clk) begin
		case (state_q)
			sfgp_pkg::SC_IDLE: begin
				prow_q <= '0;
				pcol_q <= '0;
			end
			sfgp_pkg::SC_FIND: begin
				if (pend_q) begin
					if (!sep_s1) begin
						// first glyph pixel: spacing found, height starts at one
						ls_q   <= prow_q[sfgp_pkg::POS_W-1:0];
						cs_q   <= pcol_q[sfgp_pkg::POS_W-1:0];
						gh_q   <= sfgp_pkg::DIM_W'(1);
						prow_q <= prow_q + 1'b1;
					end else if (col_next_in) begin
						pcol_q <= pcol_q + 1'b1;
					end else begin
						pcol_q <= '0;
						prow_q <= prow_q + 1'b1;
					end
				end
			end
			sfgp_pkg::SC_HGT: begin
				if (hgt_end) begin
					line_row_q <= {2'b00, ls_q};
				end else if (pend_q) begin
					gh_q   <= gh_q + 1'b1;
					prow_q <= prow_q + 1'b1;
				end
			end
			sfgp_pkg::SC_LINE: begin
				prow_q <= line_row_q[sfgp_pkg::DIM_W-1:0];
				xp_q   <= {2'b00, cs_q};
				pcol_q <= {2'b00, cs_q};
			end
			sfgp_pkg::SC_GSTART: begin
				if (probe_end) begin
					line_row_q <= line_row_q + step;
				end else if (pend_q) begin
					gw_q   <= sfgp_pkg::DIM_W'(1);
					pcol_q <= pcol_q + 1'b1;
				end
			end
			sfgp_pkg::SC_WIDTH: begin
				if (pend_q && !probe_end) begin
					gw_q   <= gw_q + 1'b1;
					pcol_q <= pcol_q + 1'b1;
				end
			end
			sfgp_pkg::SC_RECORD: begin
				// next glyph starts one gap past this one
				xp_q   <= xp_q + {1'b0, gw_q} + {2'b00, cs_q};
				pcol_q <= xp_q + {1'b0, gw_q} + {2'b00, cs_q};
			end
			default: ;
		endcase
	end

	// Record write and status towards the top level
	assign gwr.we    = (state_q == sfgp_pkg::SC_RECORD) && !full;
	assign gwr.addr  = count_q[sfgp_pkg::GLYPH_AW-1:0];
	assign gwr.rec.x = xp_q[sfgp_pkg::POS_W-1:0];
	assign gwr.rec.y = prow_q[sfgp_pkg::POS_W-1:0];
	assign gwr.rec.w = gw_q;
	assign gwr.rec.h = gh_q;

	assign stat.done   = state_q == sfgp_pkg::SC_DONE;
	assign stat.count  = count_q;
	assign stat.status = status_q;

endmodule

// ===== design/sprite_font_glyph_parser.sv =====
// Sprite-font glyph parser. Requests are taken when start is high and busy is low; every
// request gives exactly one result, shown for one cycle with done high, and the receiver
// cannot hold it off. A pixel push without last_pixel gives its result in the next cycle. A record
// read goes through the glyph table read register and then the result register. The push that
// carries last_pixel holds busy while the parser walks the separator map through its single
// registered read port.

`include "sprite_font_glyph_parser_macros.svh"

module sprite_font_glyph_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            req_type,
	input  logic [sfgp_pkg::CHAN_W-1:0]     red,
	input  logic [sfgp_pkg::CHAN_W-1:0]     green,
	input  logic [sfgp_pkg::CHAN_W-1:0]     blue,
	input  logic [sfgp_pkg::CHAN_W-1:0]     alpha,
	input  logic                            last_pixel,
	input  logic [sfgp_pkg::GLYPH_AW-1:0]   glyph_index,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [sfgp_pkg::DIM_W-1:0]      cfg_wdata,
	output logic                            done,
	output logic [sfgp_pkg::COUNT_W-1:0]    glyph_count,
	output logic [1:0]                      status,
	output logic [sfgp_pkg::POS_W-1:0]      glyph_x,
	output logic [sfgp_pkg::POS_W-1:0]      glyph_y,
	output logic [sfgp_pkg::DIM_W-1:0]      glyph_w,
	output logic [sfgp_pkg::DIM_W-1:0]      glyph_h,
	output logic [sfgp_pkg::CODE_W-1:0]     glyph_code
);

	// Image size registers
	logic [sfgp_pkg::DIM_W-1:0] width_q, height_q;
	sfgp_pkg::dims_t            dims;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sfgp_pkg::RST_WIDTH;
			height_q <= sfgp_pkg::RST_HEIGHT;
		end else if (cfg_we) begin
			unique case (sfgp_pkg::reg_idx_t'(cfg_index))
				sfgp_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_wdata;
				sfgp_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Zero reads as one, anything past the maximum as the maximum
	always_comb begin
		dims.w = width_q;
		if (width_q == '0) begin
			dims.w = sfgp_pkg::DIM_W'(1);
		end else if (width_q > sfgp_pkg::MAX_W_DIM) begin
			dims.w = sfgp_pkg::MAX_W_DIM;
		end
		dims.h = height_q;
		if (height_q == '0) begin
			dims.h = sfgp_pkg::DIM_W'(1);
		end else if (height_q > sfgp_pkg::MAX_H_DIM) begin
			dims.h = sfgp_pkg::MAX_H_DIM;
		end
	end

	// Request decode
	sfgp_pkg::top_state_t  state_q, state_d;
	sfgp_pkg::push_t       push;
	sfgp_pkg::glyph_wr_t   gwr;
	sfgp_pkg::parse_stat_t stat;
	logic                  accept, rd_accept, result_load;

	assign busy      = state_q != sfgp_pkg::TS_IDLE;
	assign accept    = start && !busy;
	assign rd_accept = accept && (req_type == sfgp_pkg::REQ_READ);

	assign push.valid = accept && (req_type == sfgp_pkg::REQ_PUSH);
	assign push.mag   = (red == sfgp_pkg::CHAN_FULL) && (green == '0)
		&& (blue == sfgp_pkg::CHAN_FULL) && (alpha == sfgp_pkg::CHAN_FULL);
	assign push.last  = last_pixel;

	sfgp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.dims   (dims),
		.push   (push),
		.gwr    (gwr),
		.stat   (stat)
	);

	// Glyph table, written by the parser, read by record requests
	sfgp_pkg::glyph_rec_t          glyph_mem [sfgp_pkg::MAX_GLYPHS];
	sfgp_pkg::glyph_rec_t          rec_s1;
	logic [sfgp_pkg::GLYPH_AW-1:0] idx_s1;
	logic                          in_range;

	always_ff @(posedge clk) begin
		if (gwr.we) begin
			glyph_mem[gwr.addr] <= gwr.rec;
		end
		if (rd_accept) begin
			rec_s1 <= glyph_mem[glyph_index];
			idx_s1 <= glyph_index;
		end
	end

	assign in_range = {1'b0, idx_s1} < stat.count;

	// Request sequencing
	always_comb begin
		state_d     = state_q;
		result_load = 1'b0;
		unique case (state_q)
			sfgp_pkg::TS_IDLE: begin
				if (push.valid) begin
					if (last_pixel) begin
						state_d = sfgp_pkg::TS_PARSE;
					end else begin
						result_load = 1'b1;
					end
				end else if (rd_accept) begin
					state_d = sfgp_pkg::TS_READ;
				end
			end
			sfgp_pkg::TS_PARSE: begin
				if (stat.done) begin
					result_load = 1'b1;
					state_d     = sfgp_pkg::TS_IDLE;
				end
			end
			sfgp_pkg::TS_READ: begin
				result_load = 1'b1;
				state_d     = sfgp_pkg::TS_IDLE;
			end
			default: begin
				state_d = sfgp_pkg::TS_IDLE;
			end
		endcase
	end

	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfgp_pkg::TS_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= result_load;
		end
	end

	// Result register
	logic [sfgp_pkg::COUNT_W-1:0] count_q;
	sfgp_pkg::status_t            status_q;
	sfgp_pkg::glyph_rec_t         rec_q;
	logic [sfgp_pkg::CODE_W-1:0]  code_q;

	always_ff @(posedge clk) begin
		if (result_load) begin
			count_q <= stat.count;
			if (state_q == sfgp_pkg::TS_READ && in_range) begin
				status_q <= stat.status;
				rec_q    <= rec_s1;
				code_q   <= sfgp_pkg::FIRST_CODE + sfgp_pkg::CODE_W'(idx_s1);
			end else begin
				status_q <= (state_q == sfgp_pkg::TS_READ) ? sfgp_pkg::STAT_RANGE : stat.status;
				rec_q    <= '0;
				code_q   <= '0;
			end
		end
	end

	assign done        = done_q;
	assign glyph_count = count_q;
	assign status      = status_q;
	assign glyph_x     = rec_q.x;
	assign glyph_y     = rec_q.y;
	assign glyph_w     = rec_q.w;
	assign glyph_h     = rec_q.h;
	assign glyph_code  = code_q;

	// Checks
	`SFGP_ASSERT_NOW(a_empty_no_count, done_q && status_q == sfgp_pkg::STAT_EMPTY, count_q == '0, "empty parse reports glyphs")
	`SFGP_ASSERT_NOW(a_range_zeroed, done_q && status_q == sfgp_pkg::STAT_RANGE, code_q == '0 && rec_q.w == '0, "out of range read carries a record")
	`SFGP_ASSERT_NEXT(a_read_two_cycles, rd_accept, busy && !done_q, "read result too early")
	`SFGP_ASSERT_NOW(a_count_capped, done_q, count_q <= sfgp_pkg::GLYPH_CAP, "glyph count beyond table size")

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import sfgp_pkg::*;

	localparam int RANDOM_ITEMS   = 400;
	localparam int WATCHDOG_LIMIT = 500000;
	localparam logic [31:0] MAGENTA = {CHAN_FULL, 8'h00, CHAN_FULL, CHAN_FULL};

	// One request as presented on the input ports
	typedef struct {
		req_t                kind;
		logic [CHAN_W-1:0]   red;
		logic [CHAN_W-1:0]   green;
		logic [CHAN_W-1:0]   blue;
		logic [CHAN_W-1:0]   alpha;
		logic                last;
		logic [GLYPH_AW-1:0] index;
	} glyph_req_t;

	// One result as seen on the output ports
	typedef struct {
		logic [COUNT_W-1:0] count;
		status_t            status;
		logic [POS_W-1:0]   x;
		logic [POS_W-1:0]   y;
		logic [DIM_W-1:0]   w;
		logic [DIM_W-1:0]   h;
		logic [CODE_W-1:0]  code;
	} glyph_reply_t;

	// Shadow of the parser: separator map, glyph table and parse state
	class glyph_scoreboard;
		bit           sep_map [MAP_DEPTH];
		int unsigned  wr_ptr;
		int unsigned  map_filled;
		glyph_rec_t   glyphs [MAX_GLYPHS];
		int unsigned  found;
		status_t      parse_stat;
		logic [DIM_W-1:0] width_reg;
		logic [DIM_W-1:0] height_reg;
		glyph_reply_t replies_due [$];
		int unsigned  errors;

		function new();
			wr_ptr = 0;
			map_filled = 0;
			found = 0;
			parse_stat = STAT_OK;
			width_reg = RST_WIDTH;
			height_reg = RST_HEIGHT;
			errors = 0;
		endfunction

		function int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned maxv);
			if (v == '0) return 1;
			if (v > maxv) return maxv;
			return v;
		endfunction

		function int unsigned cols();
			return clamp_dim(width_reg, MAX_IMAGE_WIDTH);
		endfunction

		function int unsigned rows();
			return clamp_dim(height_reg, MAX_IMAGE_HEIGHT);
		endfunction

		function void write_reg(reg_idx_t idx, logic [DIM_W-1:0] value);
			if (idx == REG_IMAGE_WIDTH) width_reg = value;
			else height_reg = value;
		endfunction

		function bit is_sep(int unsigned r, int unsigned c, int unsigned w);
			return sep_map[r * w + c];
		endfunction

		// Walk the map: first glyph pixel, glyph height, then the top row of each line
		function void parse_font_map();
			int unsigned w, h, cs, ls, gh, row, xp, gw;
			bit hit;
			w = cols();
			h = rows();
			found = 0;
			parse_stat = STAT_OK;
			hit = 0;
			cs = 0;
			ls = 0;
			for (int unsigned r = 0; r < h && !hit; r++) begin
				for (int unsigned c = 0; c < w && !hit; c++) begin
					if (!is_sep(r, c, w)) begin
						hit = 1;
						ls = r;
						cs = c;
					end
				end
			end
			if (!hit) begin
				parse_stat = STAT_EMPTY;
				return;
			end
			gh = 0;
			while (ls + gh < h && !is_sep(ls + gh, cs, w)) gh++;
			for (int unsigned line = 0; ls + line * (gh + ls) < h; line++) begin
				row = ls + line * (gh + ls);
				xp = cs;
				while (xp < w && !is_sep(row, xp, w)) begin
					gw = 0;
					while (xp + gw < w && !is_sep(row, xp + gw, w)) gw++;
					if (found >= MAX_GLYPHS) begin
						parse_stat = STAT_OVERFLOW;
						return;
					end
					glyphs[found].x = POS_W'(xp);
					glyphs[found].y = POS_W'(row);
					glyphs[found].w = DIM_W'(gw);
					glyphs[found].h = DIM_W'(gh);
					found++;
					xp += gw + cs;
				end
			end
		endfunction

		// Accepted request: update the shadow state and queue the result it causes
		function void note_request(glyph_req_t rq);
			glyph_reply_t rp;
			rp.x = '0;
			rp.y = '0;
			rp.w = '0;
			rp.h = '0;
			rp.code = '0;
			if (rq.kind == REQ_PUSH) begin
				sep_map[wr_ptr] = ({rq.red, rq.green, rq.blue, rq.alpha} == MAGENTA);
				wr_ptr++;
				if (wr_ptr > map_filled) map_filled = wr_ptr;
				if (wr_ptr == MAP_DEPTH) wr_ptr = 0;
				if (rq.last) begin
					parse_font_map();
					wr_ptr = 0;
				end
				rp.status = parse_stat;
			end else if (rq.index >= found) begin
				rp.status = STAT_RANGE;
			end else begin
				rp.status = parse_stat;
				rp.x = glyphs[rq.index].x;
				rp.y = glyphs[rq.index].y;
				rp.w = glyphs[rq.index].w;
				rp.h = glyphs[rq.index].h;
				rp.code = FIRST_CODE + CODE_W'(rq.index);
			end
			rp.count = COUNT_W'(found);
			replies_due.push_back(rp);
		endfunction

		function void compare(string name, logic [8:0] want, logic [8:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_reply(glyph_reply_t got);
			glyph_reply_t want;
			if (replies_due.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
				return;
			end
			want = replies_due.pop_front();
			compare("glyph_count", want.count, got.count);
			compare("status", want.status, got.status);
			compare("glyph_x", want.x, got.x);
			compare("glyph_y", want.y, got.y);
			compare("glyph_w", want.w, got.w);
			compare("glyph_h", want.h, got.h);
			compare("glyph_code", want.code, got.code);
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic                req_type = REQ_PUSH;
	logic [CHAN_W-1:0]   red = '0;
	logic [CHAN_W-1:0]   green = '0;
	logic [CHAN_W-1:0]   blue = '0;
	logic [CHAN_W-1:0]   alpha = '0;
	logic                last_pixel = 1'b0;
	logic [GLYPH_AW-1:0] glyph_index = '0;
	logic                cfg_we = 1'b0;
	logic                cfg_index = REG_IMAGE_WIDTH;
	logic [DIM_W-1:0]    cfg_wdata = '0;
	logic                done;
	logic [COUNT_W-1:0]  glyph_count;
	logic [1:0]          status;
	logic [POS_W-1:0]    glyph_x;
	logic [POS_W-1:0]    glyph_y;
	logic [DIM_W-1:0]    glyph_w;
	logic [DIM_W-1:0]    glyph_h;
	logic [CODE_W-1:0]   glyph_code;

	glyph_scoreboard sb;
	bit font_img [MAP_DEPTH];
	int burst_left = 0;
	int items_sent = 0;
	int stall_cycles = 0;
	bit stray_reads = 0;

	sprite_font_glyph_parser DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.alpha       (alpha),
		.last_pixel  (last_pixel),
		.glyph_index (glyph_index),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.done        (done),
		.glyph_count (glyph_count),
		.status      (status),
		.glyph_x     (glyph_x),
		.glyph_y     (glyph_y),
		.glyph_w     (glyph_w),
		.glyph_h     (glyph_h),
		.glyph_code  (glyph_code)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Results are taken on the edge that ends their cycle
	always @(posedge clk) begin
		glyph_reply_t got;
		if (arst_n && done) begin
			got.count = glyph_count;
			got.status = status_t'(status);
			got.x = glyph_x;
			got.y = glyph_y;
			got.w = glyph_w;
			got.h = glyph_h;
			got.code = glyph_code;
			sb.check_reply(got);
		end
	end

	// Watchdog on cycles with no request or result moving
	always @(posedge clk) begin
		if ((start && !busy) || done) stall_cycles = 0;
		else stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("sprite_font_glyph_parser test failed");
			$finish;
		end
	end

	// Present one request, wait for it to be taken, then pace the sender in bursts
	task automatic send(glyph_req_t rq);
		req_type <= rq.kind;
		red <= rq.red;
		green <= rq.green;
		blue <= rq.blue;
		alpha <= rq.alpha;
		last_pixel <= rq.last;
		glyph_index <= rq.index;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		sb.note_request(rq);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(0, 24);
			start <= 1'b0;
			repeat (($urandom_range(0, 9) == 0) ? $urandom_range(12, 30)
				: $urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic send_colour(logic [31:0] colour, bit last);
		glyph_req_t rq;
		rq.kind = REQ_PUSH;
		{rq.red, rq.green, rq.blue, rq.alpha} = colour;
		rq.last = last;
		rq.index = GLYPH_AW'($urandom);
		send(rq);
	endtask

	// Separator pixels are exact magenta; others are random or one bit off magenta
	task automatic send_pixel(bit mag, bit last);
		logic [31:0] colour;
		if (mag) begin
			colour = MAGENTA;
		end else if ($urandom_range(0, 3) == 0) begin
			colour = MAGENTA ^ (32'd1 << $urandom_range(0, 31));
		end else begin
			colour = $urandom;
			if (colour == MAGENTA) colour[0] = ~colour[0];
		end
		send_colour(colour, last);
	endtask

	task automatic send_read(int unsigned idx);
		glyph_req_t rq;
		rq.kind = REQ_READ;
		{rq.red, rq.green, rq.blue, rq.alpha} = $urandom;
		rq.last = 1'($urandom_range(0, 1));
		rq.index = GLYPH_AW'(idx);
		send(rq);
	endtask

	// Reads aimed mostly at stored records, with the edges of the count mixed in
	task automatic read_glyphs(int n);
		int unsigned cnt;
		for (int i = 0; i < n; i++) begin
			cnt = sb.found;
			case ($urandom_range(0, 7))
				0, 1, 2, 3, 4: send_read(cnt > 0 ? $urandom_range(0, cnt - 1)
					: $urandom_range(0, MAX_GLYPHS - 1));
				5: send_read(cnt > MAX_GLYPHS - 1 ? MAX_GLYPHS - 1 : cnt);
				6: send_read(MAX_GLYPHS - 1);
				default: send_read($urandom_range(0, MAX_GLYPHS - 1));
			endcase
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (sb.replies_due.size() != 0);
	endtask

	// Image size is only changed with nothing in flight
	task automatic set_image(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		sb.write_reg(REG_IMAGE_WIDTH, w);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		sb.write_reg(REG_IMAGE_HEIGHT, h);
		cfg_we <= 1'b0;
	endtask

	// Grid of glyph blocks on a magenta background
	function automatic void draw_font(int unsigned w, int unsigned h, int unsigned cs,
		int unsigned ls, int unsigned gh, int unsigned gw_max);
		int unsigned gw;
		for (int unsigned a = 0; a < w * h; a++) font_img[a] = 1;
		for (int unsigned row = ls; row < h; row += gh + ls) begin
			for (int unsigned xp = cs; xp < w; xp += gw + cs) begin
				gw = $urandom_range(1, gw_max);
				for (int unsigned r = row; r < row + gh && r < h; r++)
					for (int unsigned c = xp; c < xp + gw && c < w; c++)
						font_img[r * w + c] = 0;
			end
		end
	endfunction

	function automatic void fill_image(int unsigned area, int unsigned sep_pct);
		for (int unsigned a = 0; a < area; a++)
			font_img[a] = ($urandom_range(0, 99) < sep_pct);
	endfunction

	// Push n pixels of the image; last only goes out once the whole image is in the map
	task automatic push_font(int unsigned n);
		int unsigned area, a, reach;
		bit mag, last;
		area = sb.cols() * sb.rows();
		for (int unsigned p = 0; ; p++) begin
			a = p % MAP_DEPTH;
			if (p + MAP_DEPTH < n || a >= area) mag = 1'($urandom_range(0, 1));
			else mag = font_img[a];
			reach = (sb.map_filled > sb.wr_ptr) ? sb.map_filled : sb.wr_ptr + 1;
			last = (p + 1 >= n) && (reach >= area);
			if (stray_reads && $urandom_range(0, 19) == 0)
				send_read($urandom_range(0, MAX_GLYPHS - 1));
			send_pixel(mag, last);
			if (last) break;
		end
	endtask

	initial begin
		logic [DIM_W-1:0] w_val, h_val;
		int unsigned area, goal;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reads straight after reset find nothing stored
		send_read(0);
		send_read(MAX_GLYPHS - 1);

		// 1x1 image from zero-sized registers: empty, near-magenta, black, white
		set_image(0, 0);
		send_colour(MAGENTA, 1);
		send_read(0);
		send_colour(MAGENTA ^ 32'h0001_0000, 1);
		send_read(0);
		send_read(1);
		send_colour(32'h0000_0000, 1);
		send_colour(32'hffff_ffff, 1);
		send_read(0);

		// 3x2 image holding one glyph two wide and two high
		set_image(3, 2);
		for (int unsigned a = 0; a < 6; a++) font_img[a] = 1'(6'b101001 >> a);
		push_font(6);
		send_read(0);
		send_read(1);

		// Full-width single row: exactly a full table
		set_image(511, 0);
		draw_font(256, 1, 1, 0, 1, 1);
		push_font(256);
		read_glyphs(6);

		// Twelve glyph lines of twelve glyphs each: the table overflows
		set_image(24, 24);
		draw_font(24, 24, 1, 1, 1, 1);
		push_font(576);
		send_read(MAX_GLYPHS - 1);
		read_glyphs(5);

		// One column, full height
		set_image(0, 511);
		draw_font(1, 256, 0, 3, 5, 1);
		push_font(256);
		read_glyphs(4);

		// Random fonts on random small images, with broken sequences mixed in
		goal = items_sent + RANDOM_ITEMS;
		while (items_sent < goal) begin
			if ($urandom_range(0, 9) < 7) begin
				case ($urandom_range(0, 9))
					0: begin
						w_val = DIM_W'($urandom_range(257, 511));
						h_val = DIM_W'($urandom_range(0, 2));
					end
					1: begin
						w_val = DIM_W'($urandom_range(0, 1));
						h_val = DIM_W'($urandom_range(257, 511));
					end
					default: begin
						w_val = DIM_W'($urandom_range(0, 20));
						h_val = DIM_W'($urandom_range(0, 10));
					end
				endcase
				set_image(w_val, h_val);
			end
			area = sb.cols() * sb.rows();
			case ($urandom_range(0, 9))
				0: fill_image(area, 50);
				1: fill_image(area, 100);
				2: fill_image(area, 0);
				default: begin
					draw_font(sb.cols(), sb.rows(), $urandom_range(0, 2),
						$urandom_range(0, 2), $urandom_range(1, 4), $urandom_range(1, 4));
					if ($urandom_range(0, 3) == 0) begin
						for (int unsigned a = 0; a < area; a++)
							if ($urandom_range(0, 19) == 0) font_img[a] = !font_img[a];
					end
				end
			endcase
			stray_reads = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 9))
				7: push_font(area + $urandom_range(1, 10));
				8: push_font($urandom_range(1, area));
				9: begin
					// stray pixels first, so the image lands off its usual place
					repeat ($urandom_range(1, 5)) send_pixel(1'($urandom_range(0, 1)), 0);
					push_font(area);
				end
				default: push_font(area);
			endcase
			stray_reads = 0;
			if ($urandom_range(0, 6) == 0) drain();
			read_glyphs($urandom_range(2, 12));
		end

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0) $display("sprite_font_glyph_parser test passed");
		else $display("sprite_font_glyph_parser test failed");
		$finish;
	end

endmodule
